// File: sv/adsr_envelope_apply_defines.svh
// assertion macros shared by the envelope block
`ifndef ADSR_ENVELOPE_APPLY_DEFINES_SVH
`define ADSR_ENVELOPE_APPLY_DEFINES_SVH

// property checked only while out of reset
`define ADSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/adsr_pkg.sv
// types and constants of the adsr envelope block
package adsr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int FRAC_W      = 14;
    localparam int QUOT_W      = 18;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEVEL_W-1:0]  LEVEL_ONE    = 16'd16384;
    localparam logic [QUOT_W-1:0]   SAT_POS_Q    = 18'd32767;
    localparam logic [QUOT_W-1:0]   SAT_NEG_Q    = 18'd32768;
    localparam logic [SAMPLE_W-1:0] SAT_POS_OUT  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG_OUT  = 16'h8000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_LENGTH  = 3'd0,
        CFG_ATTACK_LEN    = 3'd1,
        CFG_DECAY_LEN     = 3'd2,
        CFG_RELEASE_LEN   = 3'd3,
        CFG_ATTACK_LEVEL  = 3'd4,
        CFG_SUSTAIN_LEVEL = 3'd5
    } t_cfg_idx;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PHASE_LONG = 2'd1,
        ST_BEYOND     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CLASS,
        F_MUL1,
        F_MUL2,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_DIV,
        B_DONE
    } t_back_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       start_req;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [1:0]                 status;
    } t_out_word;

    // sample and classification handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        t_status             status;
    } t_head;

endpackage

// File: sv/adsr_queue.sv
// two-entry first-word-fall-through queue between front and back
`include "adsr_envelope_apply_defines.svh"

module adsr_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int DEPTH = adsr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ADSR_ASSERT(a_no_overflow, i_push |-> !o_full, "push into a full queue")
    `ADSR_ASSERT(a_no_underflow, i_pop |-> !o_empty, "pop from an empty queue")

endmodule

// File: sv/adsr_front.sv
// front end: accepts words, tracks position, classifies phase, forms gain numerator
module adsr_front #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  adsr_pkg::t_in_word       i_in_word,
    input  logic [LENGTH_BITS-1:0]   i_total_length,
    input  logic [LENGTH_BITS-1:0]   i_attack_len,
    input  logic [LENGTH_BITS-1:0]   i_decay_len,
    input  logic [LENGTH_BITS-1:0]   i_release_len,
    input  logic [adsr_pkg::LEVEL_W-1:0] i_attack_level,
    input  logic [adsr_pkg::LEVEL_W-1:0] i_sustain_level,
    output logic                     o_push,
    input  logic                     i_full,
    output adsr_pkg::t_head          o_head,
    output logic [adsr_pkg::LEVEL_W+LENGTH_BITS-1:0] o_gain,
    output logic [LENGTH_BITS-1:0]   o_dlen
);

    localparam int W      = LENGTH_BITS;
    localparam int LVL_W  = adsr_pkg::LEVEL_W;
    localparam int GAIN_W = LVL_W + W;

    adsr_pkg::t_front_state r_state, n_state;

    logic [W-1:0]            r_pos;
    logic [W-1:0]            r_p;
    logic [W-1:0]            w_p;
    logic [adsr_pkg::SAMPLE_W-1:0] r_sample;
    adsr_pkg::t_status       r_status, w_status;
    logic [LVL_W-1:0]        r_x1, r_x2, w_x1, w_x2;
    logic [W-1:0]            r_y1, r_y2, w_y1, w_y2;
    logic [W-1:0]            r_dlen, w_dlen;
    logic [GAIN_W-1:0]       r_m1;
    logic [GAIN_W-1:0]       r_gain;

    logic [W+1:0]            w_sum_adr;
    logic [W:0]              w_end_decay;
    logic [W:0]              w_p_plus_r;
    logic [W-1:0]            w_dec_idx;

    // position taken for this word, restarted by a start request
    assign w_p = i_in_word.start_req ? '0 : r_pos;

    // state register and position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adsr_pkg::F_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (o_in_ready && i_in_valid) begin
                r_pos <= (&w_p) ? w_p : w_p + 1'b1;
            end
        end
    end

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        unique case (r_state)
            adsr_pkg::F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = adsr_pkg::F_CLASS;
                end
            end
            adsr_pkg::F_CLASS: n_state = adsr_pkg::F_MUL1;
            adsr_pkg::F_MUL1:  n_state = adsr_pkg::F_MUL2;
            adsr_pkg::F_MUL2:  n_state = adsr_pkg::F_PUSH;
            adsr_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = adsr_pkg::F_IDLE;
                end
            end
            default: n_state = adsr_pkg::F_IDLE;
        endcase
    end

    // phase boundaries
    assign w_sum_adr   = {2'b00, i_attack_len} + {2'b00, i_decay_len} + {2'b00, i_release_len};
    assign w_end_decay = {1'b0, i_attack_len} + {1'b0, i_decay_len};
    assign w_p_plus_r  = {1'b0, r_p} + {1'b0, i_release_len};
    assign w_dec_idx   = r_p - i_attack_len;

    // phase select and gain operands: gain = x1*y1 + x2*y2 over dlen
    always_comb begin
        w_status = adsr_pkg::ST_OK;
        w_x1     = '0;
        w_y1     = '0;
        w_x2     = '0;
        w_y2     = '0;
        w_dlen   = W'(1);
        priority if (w_sum_adr > {2'b00, i_total_length}) begin
            w_status = adsr_pkg::ST_PHASE_LONG;
        end else if (r_p >= i_total_length) begin
            w_status = adsr_pkg::ST_BEYOND;
        end else if (r_p < i_attack_len) begin
            w_x1   = i_attack_level;
            w_y1   = r_p;
            w_dlen = i_attack_len;
        end else if ({1'b0, r_p} < w_end_decay) begin
            w_x1   = i_attack_level;
            w_y1   = i_decay_len - w_dec_idx;
            w_x2   = i_sustain_level;
            w_y2   = w_dec_idx;
            w_dlen = i_decay_len;
        end else if (w_p_plus_r < {1'b0, i_total_length}) begin
            w_x1 = i_sustain_level;
            w_y1 = W'(1);
        end else begin
            w_x1   = i_sustain_level;
            w_y1   = i_total_length - W'(1) - r_p;
            w_dlen = i_release_len;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            adsr_pkg::F_IDLE: begin
                r_p      <= w_p;
                r_sample <= i_in_word.sample_in;
            end
            adsr_pkg::F_CLASS: begin
                r_status <= w_status;
                r_x1     <= w_x1;
                r_y1     <= w_y1;
                r_x2     <= w_x2;
                r_y2     <= w_y2;
                r_dlen   <= w_dlen;
            end
            adsr_pkg::F_MUL1: begin
                r_m1 <= GAIN_W'(r_x1) * GAIN_W'(r_y1);
            end
            adsr_pkg::F_MUL2: begin
                r_gain <= r_m1 + GAIN_W'(r_x2) * GAIN_W'(r_y2);
            end
            default: begin
            end
        endcase
    end

    assign o_head.sample = r_sample;
    assign o_head.status = r_status;
    assign o_gain        = r_gain;
    assign o_dlen        = r_dlen;

endmodule

// File: sv/adsr_back.sv
// back end: sample times gain, serial rounding divide, saturation, output register
`include "adsr_envelope_apply_defines.svh"

module adsr_back #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    output logic                     o_pop,
    input  adsr_pkg::t_head          i_head,
    input  logic [adsr_pkg::LEVEL_W+LENGTH_BITS-1:0] i_gain,
    input  logic [LENGTH_BITS-1:0]   i_dlen,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output adsr_pkg::t_out_word      o_out_word
);

    localparam int W      = LENGTH_BITS;
    localparam int SMP_W  = adsr_pkg::SAMPLE_W;
    localparam int FRAC_W = adsr_pkg::FRAC_W;
    localparam int QUOT_W = adsr_pkg::QUOT_W;
    localparam int CNT_W  = adsr_pkg::CNT_W;
    localparam int GAIN_W = adsr_pkg::LEVEL_W + W;
    localparam int LO_W   = GAIN_W / 2;
    localparam int HI_W   = GAIN_W - LO_W;
    localparam int NUM_W  = SMP_W + GAIN_W;
    localparam int DEN_W  = W + FRAC_W;

    adsr_pkg::t_back_state r_state, n_state;

    logic [SMP_W-1:0]     r_sample;
    adsr_pkg::t_status    r_status;
    logic [GAIN_W-1:0]    r_gain;
    logic [W-1:0]         r_dlen;
    logic [SMP_W-1:0]     r_mag;
    logic                 r_neg;
    logic [NUM_W-1:0]     r_pp;
    logic [DEN_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_lo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    adsr_pkg::t_out_word  r_out_word;

    logic                 w_neg_in;
    logic [SMP_W+LO_W-1:0] w_pp_lo;
    logic [SMP_W+HI_W-1:0] w_pp_hi;
    logic [NUM_W-1:0]     w_num;
    logic [DEN_W-1:0]     w_den;
    logic [DEN_W:0]       w_trial;
    logic [DEN_W:0]       w_diff;
    logic                 w_qbit;
    logic [SMP_W-1:0]     w_res;
    logic                 w_load_out;

    assign w_neg_in = i_head.sample[SMP_W-1];

    // partial products of magnitude times gain
    assign w_pp_lo = r_mag * r_gain[LO_W-1:0];
    assign w_pp_hi = r_mag * r_gain[GAIN_W-1:LO_W];
    assign w_num   = r_pp + (NUM_W'(w_pp_hi) << LO_W) + (NUM_W'(r_dlen) << (FRAC_W - 1));

    // one restoring divide step
    assign w_den   = {r_dlen, FRAC_W'(0)};
    assign w_trial = {r_rem, r_lo[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, w_den};
    assign w_qbit  = (w_trial >= {1'b0, w_den});

    // rounded quotient back to a signed sample, saturated
    always_comb begin
        if (r_status != adsr_pkg::ST_OK) begin
            w_res = r_sample;
        end else if (r_neg) begin
            w_res = (r_lo > adsr_pkg::SAT_NEG_Q) ? adsr_pkg::SAT_NEG_OUT
                                                 : SMP_W'(QUOT_W'(0) - r_lo);
        end else begin
            w_res = (r_lo > adsr_pkg::SAT_POS_Q) ? adsr_pkg::SAT_POS_OUT
                                                 : r_lo[SMP_W-1:0];
        end
    end

    // next state, queue pop and output load
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            adsr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_head.status == adsr_pkg::ST_OK) ? adsr_pkg::B_MUL1
                                                                 : adsr_pkg::B_DONE;
                end
            end
            adsr_pkg::B_MUL1: n_state = adsr_pkg::B_MUL2;
            adsr_pkg::B_MUL2: n_state = adsr_pkg::B_DIV;
            adsr_pkg::B_DIV: begin
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = adsr_pkg::B_DONE;
                end
            end
            adsr_pkg::B_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = adsr_pkg::B_IDLE;
                end
            end
            default: n_state = adsr_pkg::B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adsr_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            adsr_pkg::B_IDLE: begin
                r_sample <= i_head.sample;
                r_status <= i_head.status;
                r_gain   <= i_gain;
                r_dlen   <= i_dlen;
                r_neg    <= w_neg_in;
                r_mag    <= w_neg_in ? (~i_head.sample + 1'b1) : i_head.sample;
            end
            adsr_pkg::B_MUL1: begin
                r_pp <= NUM_W'(w_pp_lo);
            end
            adsr_pkg::B_MUL2: begin
                r_rem <= w_num[NUM_W-1:QUOT_W];
                r_lo  <= w_num[QUOT_W-1:0];
                r_cnt <= '0;
            end
            adsr_pkg::B_DIV: begin
                r_rem <= w_qbit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_lo  <= {r_lo[QUOT_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out_word.sample_out <= w_res;
            r_out_word.status     <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ADSR_ASSERT(a_rem_below_den, (r_state == adsr_pkg::B_DIV) |-> (r_rem < w_den), "divider remainder not below divisor")
    `ADSR_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

// File: sv/adsr_envelope_apply.sv
// top level of the adsr envelope block: config registers, front, queue and back
// Multiplies each signed 16-bit sample by a linear attack/decay/sustain/release gain
// (Q2.14 levels, phase lengths in samples) and rounds half away from zero with 16-bit
// saturation. A word with start_req set restarts the position at zero; the position then
// counts one per word and holds at its all-ones value. If attack+decay+release exceeds
// the total length the sample passes unchanged with status 1; past the total length it
// passes unchanged with status 2. The front end takes a new word only after pushing the
// last one into a two-entry queue to the back end, whose split multiply and 18-step
// serial divider handle one word at a time; a status-1 or status-2 word skips the
// multiply and divide. Configuration is written through a plain write port and must
// only change while no word is in flight.
module adsr_envelope_apply #(
    parameter int LENGTH_BITS = 24,
    parameter int CFG_W       = (LENGTH_BITS > 16) ? LENGTH_BITS : 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  adsr_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output adsr_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_wdata
);

    localparam int W      = LENGTH_BITS;
    localparam int LVL_W  = adsr_pkg::LEVEL_W;
    localparam int GAIN_W = LVL_W + W;
    localparam int HEAD_W = $bits(adsr_pkg::t_head);
    localparam int Q_W    = HEAD_W + GAIN_W + W;

    logic [W-1:0]     r_total_length;
    logic [W-1:0]     r_attack_len;
    logic [W-1:0]     r_decay_len;
    logic [W-1:0]     r_release_len;
    logic [LVL_W-1:0] r_attack_level;
    logic [LVL_W-1:0] r_sustain_level;

    logic                 w_push, w_pop, w_full, w_empty;
    adsr_pkg::t_head      w_front_head, w_back_head;
    logic [GAIN_W-1:0]    w_front_gain, w_back_gain;
    logic [W-1:0]         w_front_dlen, w_back_dlen;
    logic [Q_W-1:0]       w_q_in, w_q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length  <= '0;
            r_attack_len    <= '0;
            r_decay_len     <= '0;
            r_release_len   <= '0;
            r_attack_level  <= adsr_pkg::LEVEL_ONE;
            r_sustain_level <= adsr_pkg::LEVEL_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adsr_pkg::CFG_TOTAL_LENGTH:  r_total_length  <= i_cfg_wdata[W-1:0];
                adsr_pkg::CFG_ATTACK_LEN:    r_attack_len    <= i_cfg_wdata[W-1:0];
                adsr_pkg::CFG_DECAY_LEN:     r_decay_len     <= i_cfg_wdata[W-1:0];
                adsr_pkg::CFG_RELEASE_LEN:   r_release_len   <= i_cfg_wdata[W-1:0];
                adsr_pkg::CFG_ATTACK_LEVEL:  r_attack_level  <= i_cfg_wdata[LVL_W-1:0];
                adsr_pkg::CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_wdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    adsr_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_word       (i_in_word),
        .i_total_length  (r_total_length),
        .i_attack_len    (r_attack_len),
        .i_decay_len     (r_decay_len),
        .i_release_len   (r_release_len),
        .i_attack_level  (r_attack_level),
        .i_sustain_level (r_sustain_level),
        .o_push          (w_push),
        .i_full          (w_full),
        .o_head          (w_front_head),
        .o_gain          (w_front_gain),
        .o_dlen          (w_front_dlen)
    );

    // queue packing
    assign w_q_in = {w_front_head, w_front_gain, w_front_dlen};
    assign {w_back_head, w_back_gain, w_back_dlen} = w_q_out;

    adsr_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    // back end
    adsr_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_head      (w_back_head),
        .i_gain      (w_back_gain),
        .i_dlen      (w_back_dlen),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
